// ===== rtl/core/rhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Holds the sector code, the classified pixel record passed from the front
// end to the divider pipeline, and the division step used by both lanes.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CH_W      = 8;   // width of one color channel
    localparam int HUE_W     = 9;
    localparam int SAT_W     = 9;
    localparam int QUO_W     = 9;   // quotient width, one bit per divider stage
    localparam int DIV_STAGES = QUO_W;

    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = 2;
    localparam int OUT_DEPTH = 16;
    localparam int OUT_AW    = 4;

    localparam logic [10:0] OFFSET_RED   = 11'd1536;
    localparam logic [10:0] OFFSET_GREEN = 11'd512;
    localparam logic [10:0] OFFSET_BLUE  = 11'd1024;
    localparam logic [8:0]  FULL_TURN    = 9'd360;

    typedef enum logic [1:0] {
        SEC_GRAY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Classified pixel: everything the back end needs to finish the beat.
    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic [CH_W-1:0]   diff;
        logic [CH_W-1:0]   chroma;
        logic [CH_W-1:0]   vmax;
    } t_cls;

    // One slot of the divider pipeline, hue lane and saturation lane.
    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic [CH_W-1:0]   chroma;
        logic [CH_W-1:0]   vmax;
        logic [QUO_W-1:0]  hq;
        logic [CH_W-1:0]   hr;
        logic [QUO_W-1:0]  sq;
        logic [CH_W-1:0]   sr;
    } t_stg;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [CH_W-1:0]   val;
    } t_res;

    // One restoring division step. The partial remainder is always below
    // twice the divisor, so the new remainder fits in a channel width.
    // Returns the quotient bit above the new remainder.
    function automatic logic [CH_W:0] div_step(input logic [CH_W:0] part,
                                               input logic [CH_W-1:0] den);
        logic [CH_W:0] dif;
        dif = part - {1'b0, den};
        if (part >= {1'b0, den}) begin
            return {1'b1, dif[CH_W-1:0]};
        end else begin
            return {1'b0, part[CH_W-1:0]};
        end
    endfunction

endpackage

// ===== rtl/core/rhc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front: pixel intake and classification
// Finds the largest and smallest channel, the chroma, the hue sector and the
// signed channel difference, and holds the result in one register stage.
// ----------------------------------------------------------------------------
module rhc_front
    import rhc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    input  logic            i_mid_full,
    output logic            o_mid_push,
    output t_cls            o_cls
);

    logic            r_valid;
    t_cls            r_cls;
    t_cls            n_cls;
    logic            load;
    logic [CH_W-1:0] vmax;
    logic [CH_W-1:0] vmin;
    logic [CH_W-1:0] op_a;
    logic [CH_W-1:0] op_b;

    always_comb begin
        vmax = (i_red > i_green) ? i_red : i_green;
        if (i_blue > vmax) begin
            vmax = i_blue;
        end
        vmin = (i_red < i_green) ? i_red : i_green;
        if (i_blue < vmin) begin
            vmin = i_blue;
        end

        n_cls.vmax   = vmax;
        n_cls.chroma = vmax - vmin;

        // Ties on the maximum go to red, then green, then blue.
        if (n_cls.chroma == '0) begin
            n_cls.sector = SEC_GRAY;
            op_a         = i_green;
            op_b         = i_blue;
        end else if (vmax == i_red) begin
            n_cls.sector = SEC_RED;
            op_a         = i_green;
            op_b         = i_blue;
        end else if (vmax == i_green) begin
            n_cls.sector = SEC_GREEN;
            op_a         = i_blue;
            op_b         = i_red;
        end else begin
            n_cls.sector = SEC_BLUE;
            op_a         = i_red;
            op_b         = i_green;
        end

        n_cls.neg  = (op_a < op_b);
        n_cls.diff = n_cls.neg ? (op_b - op_a) : (op_a - op_b);
    end

    assign load       = !r_valid || !i_mid_full;
    assign full       = r_valid && i_mid_full;
    assign o_mid_push = r_valid && !i_mid_full;
    assign o_cls      = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && push) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ===== rtl/core/rhc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_queue: short queue of classified pixels
// Decouples the front end from the divider pipeline so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module rhc_queue
    import rhc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cls o_data
);

    t_cls              r_mem [MID_DEPTH];
    logic [MID_AW-1:0] r_wptr;
    logic [MID_AW-1:0] r_rptr;
    logic [MID_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (MID_AW+1)'(MID_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/rhc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back: divider pipeline, hue finish and result queue
// Two restoring dividers run side by side, one quotient bit per stage. A
// final stage scales the hue, and results wait in a queue. Beats are issued
// only against free queue slots, so the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module rhc_back
    import rhc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mid_empty,
    input  t_cls             i_cls,
    output logic             o_mid_pop,
    output logic             empty,
    input  logic             pop,
    output logic [HUE_W-1:0] o_hue,
    output logic [SAT_W-1:0] o_saturation,
    output logic [CH_W-1:0]  o_brightness
);

    logic              r_vld [DIV_STAGES];
    t_stg              r_stg [DIV_STAGES];
    t_stg              n_stg [DIV_STAGES];
    logic              r_res_vld;
    t_res              r_res;
    t_res              n_res;
    logic [OUT_AW:0]   r_credit;
    t_res              r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wptr;
    logic [OUT_AW-1:0] r_rptr;
    logic [OUT_AW:0]   r_count;
    logic              issue;
    logic              do_pop;
    logic [CH_W:0]     h_step [DIV_STAGES];
    logic [CH_W:0]     s_step [DIV_STAGES];
    logic [10:0]       offset;
    logic [10:0]       sum;
    logic [16:0]       prod;
    logic [HUE_W-1:0]  hue_raw;

    // Credits cover every beat in flight plus every beat in the queue.
    assign issue     = !i_mid_empty && (r_credit != (OUT_AW+1)'(OUT_DEPTH));
    assign o_mid_pop = issue;
    assign empty     = (r_count == '0);
    assign do_pop    = pop && !empty;

    always_comb begin
        h_step[0]        = div_step({1'b0, i_cls.diff}, i_cls.chroma);
        s_step[0]        = div_step({1'b0, i_cls.chroma}, i_cls.vmax);
        n_stg[0].sector  = i_cls.sector;
        n_stg[0].neg     = i_cls.neg;
        n_stg[0].chroma  = i_cls.chroma;
        n_stg[0].vmax    = i_cls.vmax;
        n_stg[0].hq      = {{(QUO_W-1){1'b0}}, h_step[0][CH_W]};
        n_stg[0].hr      = h_step[0][CH_W-1:0];
        n_stg[0].sq      = {{(QUO_W-1){1'b0}}, s_step[0][CH_W]};
        n_stg[0].sr      = s_step[0][CH_W-1:0];
        for (int i = 1; i < DIV_STAGES; i++) begin
            h_step[i]  = div_step({r_stg[i-1].hr, 1'b0}, r_stg[i-1].chroma);
            s_step[i]  = div_step({r_stg[i-1].sr, 1'b0}, r_stg[i-1].vmax);
            n_stg[i]    = r_stg[i-1];
            n_stg[i].hq = {r_stg[i-1].hq[QUO_W-2:0], h_step[i][CH_W]};
            n_stg[i].hr = h_step[i][CH_W-1:0];
            n_stg[i].sq = {r_stg[i-1].sq[QUO_W-2:0], s_step[i][CH_W]};
            n_stg[i].sr = s_step[i][CH_W-1:0];
        end
    end

    // Hue finish: offset plus or minus quotient, times 60, drop 8 bits.
    always_comb begin
        case (r_stg[DIV_STAGES-1].sector)
            SEC_RED:   offset = OFFSET_RED;
            SEC_GREEN: offset = OFFSET_GREEN;
            SEC_BLUE:  offset = OFFSET_BLUE;
            default:   offset = OFFSET_RED;
        endcase
        if (r_stg[DIV_STAGES-1].neg) begin
            sum = offset - {2'b0, r_stg[DIV_STAGES-1].hq};
        end else begin
            sum = offset + {2'b0, r_stg[DIV_STAGES-1].hq};
        end
        prod    = ({6'b0, sum} << 6) - ({6'b0, sum} << 2);
        hue_raw = prod[16:8];

        case (r_stg[DIV_STAGES-1].sector)
            SEC_GRAY: n_res.hue = '0;
            SEC_RED:  n_res.hue = (hue_raw >= FULL_TURN) ? (hue_raw - FULL_TURN)
                                                         : hue_raw;
            default:  n_res.hue = hue_raw;
        endcase
        // A black pixel divides by zero; its saturation is forced to zero.
        n_res.sat = (r_stg[DIV_STAGES-1].vmax == '0) ? '0 : r_stg[DIV_STAGES-1].sq;
        n_res.val = r_stg[DIV_STAGES-1].vmax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_res_vld <= 1'b0;
        end else begin
            r_vld[0] <= issue;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_res_vld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            r_stg[i] <= n_stg[i];
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
        end else begin
            case ({issue, do_pop})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
            if (r_res_vld) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({r_res_vld, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res_vld) begin
            r_mem[r_wptr] <= r_res;
        end
    end

    assign o_hue        = r_mem[r_rptr].hue;
    assign o_saturation = r_mem[r_rptr].sat;
    assign o_brightness = r_mem[r_rptr].val;

endmodule

// ===== rtl/core/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit RGB pixel to hue, saturation and value
// Usage: the source drives i_red, i_green and i_blue and raises push; a beat
// is taken at a rising edge with push high and full low. The sink sees the
// oldest result on o_hue, o_saturation and o_brightness while empty is low
// and takes it with pop at a rising edge.
// Throughput is one pixel per cycle, sustained, as long as the sink pops
// every cycle. A pixel that is accepted passes through one classify stage,
// the decoupling queue, nine divider stages (one quotient bit each for hue
// and saturation in parallel) and a hue scaling stage.
// The result queue holds 16 beats and new pixels leave the decoupling queue
// only against free result slots. When the sink stalls, the result queue
// fills, the decoupling queue backs up and full rises; nothing is dropped.
// Synchronous active-low reset empties all queues and the pipeline; no
// results are pending afterwards and full is low.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [CH_W-1:0]  i_red,
    input  logic [CH_W-1:0]  i_green,
    input  logic [CH_W-1:0]  i_blue,
    output logic             empty,
    input  logic             pop,
    output logic [HUE_W-1:0] o_hue,
    output logic [SAT_W-1:0] o_saturation,
    output logic [CH_W-1:0]  o_brightness
);

    logic mid_full;
    logic mid_push;
    logic mid_empty;
    logic mid_pop;
    t_cls front_cls;
    t_cls mid_cls;

    rhc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .i_mid_full (mid_full),
        .o_mid_push (mid_push),
        .o_cls      (front_cls)
    );

    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_cls),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_cls)
    );

    rhc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mid_empty  (mid_empty),
        .i_cls        (mid_cls),
        .o_mid_pop    (mid_pop),
        .empty        (empty),
        .pop          (pop),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

endmodule
